### design/rgsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsa_pkg
// Shared types and codes for the region gradient scatter-add engine.
// ----------------------------------------------------------------------------
package rgsa_pkg;

  // Field widths fixed by the request and result formats.
  localparam int unsigned IdxW    = 6;
  localparam int unsigned GradW   = 24;
  localparam int unsigned SumW    = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CfgIdxW = 2;

  // Request opcodes.
  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SKIP  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LABEL_COUNT = 2'd0,
    CFG_BOX_COUNT   = 2'd1
  } cfg_index_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic accept;
    logic exec;
  } rgsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } rgsa_stat_t;

endpackage

### design/rgsa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsa_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface rgsa_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   opcode;
  logic [rgsa_pkg::IdxW-1:0]              label_index;
  logic [rgsa_pkg::IdxW-1:0]              box_index;
  logic                                   box_present;
  logic signed [rgsa_pkg::GradW-1:0]      gradient;

  modport source (
    output valid, opcode, label_index, box_index, box_present, gradient,
    input  ready
  );
  modport sink (
    input  valid, opcode, label_index, box_index, box_present, gradient,
    output ready
  );
endinterface

### design/rgsa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsa_rsp_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface rgsa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [rgsa_pkg::SumW-1:0]  sum_value;
  logic [1:0]                        status;

  modport source (
    output valid, sum_value, status,
    input  ready
  );
  modport sink (
    input  valid, sum_value, status,
    output ready
  );
endinterface

### design/rgsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsa_ctrl
// Controller: clearing pass after reset, then request accept and execute.
// ----------------------------------------------------------------------------
module rgsa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rgsa_pkg::rgsa_stat_t stat_i,
  output rgsa_pkg::rgsa_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o.clear_en = 1'b0;
    cmd_o.accept   = 1'b0;
    cmd_o.exec     = 1'b0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        // Wait until the result register can take the new result.
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/rgsa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsa_dp
// Datapath: configuration, accumulator memory, saturating add, result register.
// ----------------------------------------------------------------------------
module rgsa_dp #(
  parameter int unsigned MAX_LABELS = 64,
  parameter int unsigned MAX_BOXES  = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration writes.
  input  logic                                 cfg_we_i,
  input  logic [rgsa_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [rgsa_pkg::CountW-1:0]          cfg_data_i,
  // Request fields.
  input  logic                                 opcode_i,
  input  logic [rgsa_pkg::IdxW-1:0]            label_index_i,
  input  logic [rgsa_pkg::IdxW-1:0]            box_index_i,
  input  logic                                 box_present_i,
  input  logic signed [rgsa_pkg::GradW-1:0]    gradient_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rgsa_pkg::SumW-1:0]     sum_value_o,
  output rgsa_pkg::status_e                    status_o,
  // Controller link.
  input  rgsa_pkg::rgsa_cmd_t                  cmd_i,
  output rgsa_pkg::rgsa_stat_t                 stat_o
);

  localparam int unsigned Depth = MAX_LABELS * MAX_BOXES;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SumW  = rgsa_pkg::SumW;
  localparam int unsigned GradW = rgsa_pkg::GradW;

  // Configuration registers.
  logic [rgsa_pkg::CountW-1:0] label_count_q, box_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_count_q <= rgsa_pkg::CountW'(64);
      box_count_q   <= rgsa_pkg::CountW'(64);
    end else if (cfg_we_i) begin
      if (cfg_index_i == rgsa_pkg::CFG_LABEL_COUNT) begin
        label_count_q <= cfg_data_i;
      end
      if (cfg_index_i == rgsa_pkg::CFG_BOX_COUNT) begin
        box_count_q <= cfg_data_i;
      end
    end
  end

  // Clearing pass counter.
  logic [AddrW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  assign stat_o.clear_last = (clr_cnt_q == AddrW'(Depth - 1));

  // Request decode: range check and entry address.
  logic             in_range;
  logic [31:0]      addr_full;
  rgsa_pkg::status_e pre_status;

  always_comb begin
    in_range  = (32'(label_index_i) < 32'(label_count_q)) &&
                (32'(label_index_i) < 32'(MAX_LABELS)) &&
                (32'(box_index_i) < 32'(box_count_q)) &&
                (32'(box_index_i) < 32'(MAX_BOXES));
    addr_full = 32'(box_index_i) * 32'(MAX_LABELS) + 32'(label_index_i);
    if ((opcode_i == rgsa_pkg::OP_ACCUM) && !box_present_i) begin
      pre_status = rgsa_pkg::ST_SKIP;
    end else if (!in_range) begin
      pre_status = rgsa_pkg::ST_RANGE;
    end else begin
      pre_status = rgsa_pkg::ST_OK;
    end
  end

  // Latched request.
  logic                    item_op_q;
  rgsa_pkg::status_e       item_st_q;
  logic signed [GradW-1:0] item_grad_q;
  logic [AddrW-1:0]        item_addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_op_q   <= opcode_i;
      item_st_q   <= pre_status;
      item_grad_q <= gradient_i;
      item_addr_q <= addr_full[AddrW-1:0];
    end
  end

  // Saturating add of the gradient to the stored sum.
  logic signed [SumW-1:0] rd_q;
  logic signed [SumW:0]   sum_wide;
  logic signed [SumW-1:0] sum_sat;
  logic                   sat;

  always_comb begin
    sum_wide = {rd_q[SumW-1], rd_q} + (SumW+1)'(item_grad_q);
    sat      = (sum_wide[SumW] != sum_wide[SumW-1]);
    if (!sat) begin
      sum_sat = sum_wide[SumW-1:0];
    end else if (sum_wide[SumW]) begin
      sum_sat = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SumW-1){1'b1}}};
    end
  end

  // Memory write port: clearing pass or executed request.
  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic signed [SumW-1:0] mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = item_addr_q;
    mem_wdata = '0;
    if (cmd_i.clear_en) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
    end else if (cmd_i.exec && (item_st_q == rgsa_pkg::ST_OK)) begin
      mem_we    = 1'b1;
      mem_wdata = (item_op_q == rgsa_pkg::OP_READ) ? '0 : sum_sat;
    end
  end

  // Accumulator memory, registered read on request accept.
  logic signed [SumW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.accept) begin
      rd_q <= mem_q[addr_full[AddrW-1:0]];
    end
  end

  // Result register.
  logic                   out_valid_q;
  logic signed [SumW-1:0] out_sum_q;
  rgsa_pkg::status_e      out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (item_st_q != rgsa_pkg::ST_OK) begin
        out_sum_q    <= '0;
        out_status_q <= item_st_q;
      end else if (item_op_q == rgsa_pkg::OP_READ) begin
        out_sum_q    <= rd_q;
        out_status_q <= rgsa_pkg::ST_OK;
      end else begin
        out_sum_q    <= sum_sat;
        out_status_q <= sat ? rgsa_pkg::ST_SAT : rgsa_pkg::ST_OK;
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign sum_value_o     = out_sum_q;
  assign status_o        = out_status_q;

endmodule

### design/region_gradient_scatter_add.sv
`timescale 1ns / 1ps
// A request is accepted in the idle state and waits in the execute state until
// the result register is free; its result is then registered there.
// A new request is accepted only after the previous one has executed; the single
// accumulator memory is read in the accept cycle and written in the execute cycle.
// Reset: after rst_ni the controller clears the memory one entry per cycle, all
// MAX_LABELS * MAX_BOXES entries (4096 by default), with request ready low.
// ----------------------------------------------------------------------------
// region_gradient_scatter_add
// Scatter-add engine: saturating per-entry gradient accumulation and
// read-and-clear of label/box accumulators.
// ----------------------------------------------------------------------------
module region_gradient_scatter_add #(
  parameter int unsigned MAX_LABELS = 64,
  parameter int unsigned MAX_BOXES  = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rgsa_req_if.sink                      req_in,
  rgsa_rsp_if.source                    rsp_out,
  input  logic                          cfg_we_i,
  input  logic [rgsa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rgsa_pkg::CountW-1:0]   cfg_data_i
);

  rgsa_pkg::rgsa_cmd_t  cmd;
  rgsa_pkg::rgsa_stat_t stat;
  rgsa_pkg::status_e    status;

  // Controller.
  rgsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_in.valid),
    .in_ready_o (req_in.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath.
  rgsa_dp #(
    .MAX_LABELS (MAX_LABELS),
    .MAX_BOXES  (MAX_BOXES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (req_in.opcode),
    .label_index_i (req_in.label_index),
    .box_index_i   (req_in.box_index),
    .box_present_i (req_in.box_present),
    .gradient_i    (req_in.gradient),
    .out_valid_o   (rsp_out.valid),
    .out_ready_i   (rsp_out.ready),
    .sum_value_o   (rsp_out.sum_value),
    .status_o      (status),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

  assign rsp_out.status = status;

`ifndef ASSERT_OFF
  // One request at a time: ready drops right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_in.valid && req_in.ready) |=> !req_in.ready)
    else $error("request accepted while another is in flight");

  // A saturated result carries one of the two bounds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_out.valid && (rsp_out.status == rgsa_pkg::ST_SAT)) |->
    ((rsp_out.sum_value == 32'sh7fffffff) || (rsp_out.sum_value == 32'sh80000000)))
    else $error("saturated result is not a bound");

  // Skipped and out-of-range results carry a zero sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_out.valid && ((rsp_out.status == rgsa_pkg::ST_SKIP) ||
                       (rsp_out.status == rgsa_pkg::ST_RANGE))) |->
    (rsp_out.sum_value == '0))
    else $error("rejected request returned a nonzero sum");
`endif

endmodule
